>>> hw/rtl/cbss_pkg.sv
`timescale 1ns / 1ps

package cbss_pkg;

    localparam int CBSS_MAX_STEPS_LOG2 = 5;

    localparam int COORD_W = 32;
    // -P0 + 3P1 - 3P2 + P3 and its kin need at most 36 bits from 32-bit points
    localparam int COEF_W  = 36;
    localparam int STEPS_W = 3;

    typedef logic [STEPS_W-1:0] t_steps;

    localparam t_steps STEPS_LOG2_RESET = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
    } t_segment;

    typedef struct packed {
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
        logic                      last_sample;
    } t_sample;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } t_coef;

    typedef struct packed {
        t_coef  x;
        t_coef  y;
        t_steps k;
    } t_seg_coef;

    // Bezier basis matrix applied to one axis
    function automatic t_coef bezier_coef(
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2,
        input logic signed [COORD_W-1:0] p3
    );
        logic signed [COEF_W-1:0] e0;
        logic signed [COEF_W-1:0] e1;
        logic signed [COEF_W-1:0] e2;
        logic signed [COEF_W-1:0] e3;
        logic signed [COEF_W-1:0] u;
        logic signed [COEF_W-1:0] v;
        logic signed [COEF_W-1:0] w;
        t_coef                    r;
        e0  = COEF_W'(p0);
        e1  = COEF_W'(p1);
        e2  = COEF_W'(p2);
        e3  = COEF_W'(p3);
        u   = e1 - e2;
        v   = e0 - e1 - e1 + e2;
        w   = e1 - e0;
        r.a = e3 - e0 + (u <<< 1) + u;
        r.b = (v <<< 1) + v;
        r.c = (w <<< 1) + w;
        r.d = e0;
        return r;
    endfunction

endpackage

>>> hw/rtl/cbss_chan_if.sv
`timescale 1ns / 1ps

interface cbss_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/cubic_bezier_segment_sampler_unit.sv
`timescale 1ns / 1ps

// Cubic Bezier segment sampler.
// i_seg takes one segment per transfer: four control points, x and y in
// signed Q16.16. o_smp returns 2^k + 1 samples of the curve at t = j / 2^k,
// j rising from 0, each rounded to Q16.16 and saturated; last_sample marks
// the sample at t = 1. i_cfg sets k (steps_log2); values above
// MAX_STEPS_LOG2 act as MAX_STEPS_LOG2. Write it only while the block is
// idle; it takes effect on the next segment transfer.
// The sample sequencer issues one sample per cycle while the receiver does
// not stall; consecutive segments follow with no gap. A one-segment holding
// register takes the next segment while the current one is still being
// sampled. With the sequencer free, the first sample of a segment passes the
// holding register, sequencer, multiply, partial sums, sum and shift, then
// saturation into the output register before it appears on o_smp.
// Reset clears every valid bit and sets k to 4. When the receiver stalls,
// the whole sample pipeline and the sequencer hold; the holding register
// still takes one further segment.

module cubic_bezier_segment_sampler_unit
    import cbss_pkg::*;
#(
    parameter  int MAX_STEPS_LOG2 = CBSS_MAX_STEPS_LOG2,
    localparam int JW             = MAX_STEPS_LOG2 + 1,
    localparam int J2W            = 2 * MAX_STEPS_LOG2 + 1,
    localparam int J3W            = 3 * MAX_STEPS_LOG2 + 1
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbss_chan_if.sink   i_cfg,
    cbss_chan_if.sink   i_seg,
    cbss_chan_if.source o_smp
);

    // stages of the arithmetic lanes behind the sequencer
    localparam int AXIS_STAGES = 4;

    t_steps                    r_steps_log2;
    logic [AXIS_STAGES-1:0]    r_vld;
    logic [AXIS_STAGES-1:0]    r_lst;
    logic                      en;
    logic                      hold_valid;
    t_seg_coef                 hold_seg;
    logic                      seg_take;
    logic                      seq_valid;
    logic                      seq_last;
    t_seg_coef                 seq_seg;
    logic [JW-1:0]             seq_j;
    logic [J2W-1:0]            seq_j2;
    logic [J3W-1:0]            seq_j3;
    logic signed [COORD_W-1:0] x_value;
    logic signed [COORD_W-1:0] y_value;
    t_sample                   smp;

    // Configuration: always ready, one register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_log2 <= STEPS_LOG2_RESET;
        end else if (i_cfg.valid) begin
            r_steps_log2 <= i_cfg.data;
        end
    end

    // Advance the sequencer and both lanes unless a finished sample is stuck
    assign en = !r_vld[AXIS_STAGES-1] || o_smp.ready;

    // Holding register: coefficients of the next segment
    cbss_coef #(
        .MAX_STEPS_LOG2(MAX_STEPS_LOG2)
    ) u_coef (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg_valid  (i_seg.valid),
        .o_seg_ready  (i_seg.ready),
        .i_seg        (i_seg.data),
        .i_steps_log2 (r_steps_log2),
        .o_valid      (hold_valid),
        .i_take       (seg_take),
        .o_seg        (hold_seg)
    );

    // Sample sequencer: one j per cycle while not stalled, loads the next segment on the last
    cbss_seq #(
        .MAX_STEPS_LOG2(MAX_STEPS_LOG2)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_seg_valid (hold_valid),
        .o_seg_take  (seg_take),
        .i_seg       (hold_seg),
        .o_valid     (seq_valid),
        .o_last      (seq_last),
        .o_seg       (seq_seg),
        .o_j         (seq_j),
        .o_j2        (seq_j2),
        .o_j3        (seq_j3)
    );

    cbss_axis #(
        .MAX_STEPS_LOG2(MAX_STEPS_LOG2)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coef  (seq_seg.x),
        .i_k     (seq_seg.k),
        .i_j     (seq_j),
        .i_j2    (seq_j2),
        .i_j3    (seq_j3),
        .o_value (x_value)
    );

    cbss_axis #(
        .MAX_STEPS_LOG2(MAX_STEPS_LOG2)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coef  (seq_seg.y),
        .i_k     (seq_seg.k),
        .i_j     (seq_j),
        .i_j2    (seq_j2),
        .i_j3    (seq_j3),
        .o_value (y_value)
    );

    // Valid and last flags travel alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[AXIS_STAGES-2:0], seq_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lst <= {r_lst[AXIS_STAGES-2:0], seq_last};
        end
    end

    assign smp.sample_x    = x_value;
    assign smp.sample_y    = y_value;
    assign smp.last_sample = r_lst[AXIS_STAGES-1];

    assign o_smp.valid = r_vld[AXIS_STAGES-1];
    assign o_smp.data  = smp;

endmodule

>>> hw/rtl/cbss_coef.sv
`timescale 1ns / 1ps

module cbss_coef
    import cbss_pkg::*;
#(
    parameter int MAX_STEPS_LOG2 = CBSS_MAX_STEPS_LOG2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_seg_valid,
    output logic      o_seg_ready,
    input  t_segment  i_seg,
    input  t_steps    i_steps_log2,
    output logic      o_valid,
    input  logic      i_take,
    output t_seg_coef o_seg
);

    logic      r_valid;
    t_seg_coef r_seg;
    logic      accept;
    t_steps    steps_clamped;

    assign accept        = i_seg_valid && !r_valid;
    assign steps_clamped = (i_steps_log2 > STEPS_W'(MAX_STEPS_LOG2)) ?
                           STEPS_W'(MAX_STEPS_LOG2) : i_steps_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg.x <= bezier_coef(i_seg.p0_x, i_seg.p1_x, i_seg.p2_x, i_seg.p3_x);
            r_seg.y <= bezier_coef(i_seg.p0_y, i_seg.p1_y, i_seg.p2_y, i_seg.p3_y);
            r_seg.k <= steps_clamped;
        end
    end

    assign o_seg_ready = !r_valid;
    assign o_valid     = r_valid;
    assign o_seg       = r_seg;

endmodule

>>> hw/rtl/cbss_seq.sv
`timescale 1ns / 1ps

module cbss_seq
    import cbss_pkg::*;
#(
    parameter  int MAX_STEPS_LOG2 = CBSS_MAX_STEPS_LOG2,
    localparam int JW             = MAX_STEPS_LOG2 + 1,
    localparam int J2W            = 2 * MAX_STEPS_LOG2 + 1,
    localparam int J3W            = 3 * MAX_STEPS_LOG2 + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_seg_valid,
    output logic           o_seg_take,
    input  t_seg_coef      i_seg,
    output logic           o_valid,
    output logic           o_last,
    output t_seg_coef      o_seg,
    output logic [JW-1:0]  o_j,
    output logic [J2W-1:0] o_j2,
    output logic [J3W-1:0] o_j3
);

    logic           r_valid;
    logic           r_last;
    t_seg_coef      r_seg;
    logic [JW-1:0]  r_j;
    logic [J2W-1:0] r_j2;
    logic [J3W-1:0] r_j3;
    logic [JW-1:0]  n_j;
    logic [J2W-1:0] n_j2;
    logic [J3W-1:0] n_j3;
    logic [JW-1:0]  step_count;
    logic           slot_free;
    logic           take;
    logic           step;

    assign slot_free  = !r_valid || (i_en && r_last);
    assign take       = slot_free && i_seg_valid;
    assign step       = i_en && r_valid && !r_last;
    assign step_count = JW'(1) << r_seg.k;

    // Powers of j by forward differences
    assign n_j  = r_j + JW'(1);
    assign n_j2 = r_j2 + J2W'({r_j, 1'b0}) + J2W'(1);
    assign n_j3 = r_j3 + J3W'({r_j2, 1'b0}) + J3W'(r_j2)
                + J3W'({r_j, 1'b0}) + J3W'(r_j) + J3W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_last  <= 1'b0;
        end else if (i_en && r_valid && r_last) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_last <= (n_j == step_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_seg <= i_seg;
            r_j   <= '0;
            r_j2  <= '0;
            r_j3  <= '0;
        end else if (step) begin
            r_j  <= n_j;
            r_j2 <= n_j2;
            r_j3 <= n_j3;
        end
    end

    assign o_seg_take = take;
    assign o_valid    = r_valid;
    assign o_last     = r_last;
    assign o_seg      = r_seg;
    assign o_j        = r_j;
    assign o_j2       = r_j2;
    assign o_j3       = r_j3;

endmodule

>>> hw/rtl/cbss_axis.sv
`timescale 1ns / 1ps

module cbss_axis
    import cbss_pkg::*;
#(
    parameter  int MAX_STEPS_LOG2 = CBSS_MAX_STEPS_LOG2,
    localparam int JW             = MAX_STEPS_LOG2 + 1,
    localparam int J2W            = 2 * MAX_STEPS_LOG2 + 1,
    localparam int J3W            = 3 * MAX_STEPS_LOG2 + 1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_coef                     i_coef,
    input  t_steps                    i_k,
    input  logic [JW-1:0]             i_j,
    input  logic [J2W-1:0]            i_j2,
    input  logic [J3W-1:0]            i_j3,
    output logic signed [COORD_W-1:0] o_value
);

    localparam int NUM_W = COEF_W + 3 * MAX_STEPS_LOG2 + 2;
    localparam int SH_W  = $clog2(3 * MAX_STEPS_LOG2 + 1);
    localparam int T1_W  = COEF_W + JW + 1;
    localparam int T2_W  = COEF_W + J2W + 1;
    localparam int T3_W  = COEF_W + J3W + 1;

    localparam logic signed [NUM_W-1:0] SAT_HI =
        {{(NUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [NUM_W-1:0] SAT_LO =
        {{(NUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    logic signed [T1_W-1:0]    r1_t1;
    logic signed [T2_W-1:0]    r1_t2;
    logic signed [T3_W-1:0]    r1_t3;
    logic signed [COEF_W-1:0]  r1_d;
    logic [SH_W-1:0]           r1_sh1;
    logic [SH_W-1:0]           r1_sh2;
    logic [SH_W-1:0]           r1_sh3;
    logic signed [NUM_W-1:0]   r2_hi;
    logic signed [NUM_W-1:0]   r2_lo;
    logic [SH_W-1:0]           r2_sh3;
    logic signed [NUM_W-1:0]   r3_q;
    logic signed [COORD_W-1:0] r4_value;
    logic [SH_W-1:0]           k_sh;
    logic signed [NUM_W-1:0]   rnd;

    assign k_sh = SH_W'(i_k);
    // half of one output step, so the floor shift rounds ties upward
    assign rnd  = (r1_sh3 == '0) ? '0 : (NUM_W'(1) << (r1_sh3 - SH_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // multiply by the powers of j
            r1_t1  <= i_coef.c * $signed({1'b0, i_j});
            r1_t2  <= i_coef.b * $signed({1'b0, i_j2});
            r1_t3  <= i_coef.a * $signed({1'b0, i_j3});
            r1_d   <= i_coef.d;
            r1_sh1 <= k_sh;
            r1_sh2 <= k_sh + k_sh;
            r1_sh3 <= k_sh + k_sh + k_sh;

            // powers of n are shifts
            r2_hi  <= NUM_W'(r1_t3) + (NUM_W'(r1_t2) <<< r1_sh1);
            r2_lo  <= (NUM_W'(r1_t1) <<< r1_sh2) + (NUM_W'(r1_d) <<< r1_sh3) + rnd;
            r2_sh3 <= r1_sh3;

            // divide by n cubed
            r3_q   <= (r2_hi + r2_lo) >>> r2_sh3;

            if (r3_q > SAT_HI) begin
                r4_value <= SAT_HI[COORD_W-1:0];
            end else if (r3_q < SAT_LO) begin
                r4_value <= SAT_LO[COORD_W-1:0];
            end else begin
                r4_value <= r3_q[COORD_W-1:0];
            end
        end
    end

    assign o_value = r4_value;

endmodule

>>> hw/rtl/cbss_checker.sv
`timescale 1ns / 1ps

module cbss_checker
    import cbss_pkg::*;
#(
    parameter  int MAX_STEPS_LOG2 = CBSS_MAX_STEPS_LOG2,
    localparam int JW             = MAX_STEPS_LOG2 + 1
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_cfg_valid,
    input logic    i_cfg_ready,
    input t_steps  i_cfg_data,
    input logic    i_seg_valid,
    input logic    i_seg_ready,
    input logic    i_smp_valid,
    input logic    i_smp_ready,
    input t_sample i_smp_data
);

    t_steps        r_steps;
    logic [JW-1:0] r_cnt;
    t_steps        steps_clamped;
    logic [JW-1:0] step_count;
    logic          smp_xfer;

    assign smp_xfer      = i_smp_valid && i_smp_ready;
    assign steps_clamped = (r_steps > STEPS_W'(MAX_STEPS_LOG2)) ?
                           STEPS_W'(MAX_STEPS_LOG2) : r_steps;
    assign step_count    = JW'(1) << steps_clamped;

    // Mirror the step register and count samples in the current segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_LOG2_RESET;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                r_steps <= i_cfg_data;
            end
            if (smp_xfer) begin
                r_cnt <= i_smp_data.last_sample ? '0 : r_cnt + JW'(1);
            end
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_smp_valid && !i_smp_ready |=> i_smp_valid && $stable(i_smp_data))
        else $error("sample changed or dropped while stalled");

    a_group_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        smp_xfer |-> (i_smp_data.last_sample == (r_cnt == step_count)))
        else $error("last sample flag does not close a group of 2^k + 1");

    a_seg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg_valid && i_seg_ready |=> !i_seg_ready)
        else $error("segment taken while the holding register is full");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_smp_valid && i_seg_ready)
        else $error("reset did not empty the block");

endmodule

bind cubic_bezier_segment_sampler_unit cbss_checker #(
    .MAX_STEPS_LOG2(MAX_STEPS_LOG2)
) u_cbss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_data  (i_cfg.data),
    .i_seg_valid (i_seg.valid),
    .i_seg_ready (i_seg.ready),
    .i_smp_valid (o_smp.valid),
    .i_smp_ready (o_smp.ready),
    .i_smp_data  (o_smp.data)
);
